// ===== rtl/core/cbd_pkg.sv =====
// Shared constants, types and helpers for the chunked body decoder.
`default_nettype none

package cbd_pkg;

    // Width of the decoded length count
    localparam int LENGTH_BITS    = 32;
    // Longest accepted size line, in hex digits
    localparam int MAX_HEX_DIGITS = 8;
    // Width of a chunk size built from the longest size line
    localparam int SIZE_BITS      = 4 * MAX_HEX_DIGITS;
    // Digit counter holds 0 .. MAX_HEX_DIGITS
    localparam int DCNT_BITS      = $clog2(MAX_HEX_DIGITS + 1);
    // Result tdata: data byte, then decoded length, padded to whole bytes
    localparam int M_TDATA_BITS   = ((8 + LENGTH_BITS + 7) / 8) * 8;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Framing phase, one-hot
    typedef enum logic [5:0] {
        PH_SIZE  = 6'b000001,
        PH_LF    = 6'b000010,
        PH_BAD   = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_TRAIL = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    // One decoded result
    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   has_data;
        logic                   body_done;
        logic                   malformed;
        logic [LENGTH_BITS-1:0] decoded_length;
    } result_t;

    // Decode an ASCII hex digit: bit 4 is valid, bits 3:0 the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'b0_0000;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbd_out_buf.sv =====
// Two-entry result buffer between the decode stage and the result channel.
`default_nettype none

module cbd_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cbd_pkg::result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cbd_pkg::result_t      out_data
);
    import cbd_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/chunked_body_decoder_core.sv =====
// Top level of the chunked body decoder: framing state and result channel.
//
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tdata body_byte, s_tlast stream_end
// m_        out  m_tvalid / m_tready    m_tdata data_byte + length, m_tuser flags,
//                                       m_tlast body_done
// cfg_      in   cfg_valid / cfg_ready  cfg_data chunked_mode
//
// One byte per cycle while s_tready is high: each accepted byte updates the framing state in the
// same cycle and its result, if any, is written into a two-entry buffer.
// The first result shows on m_ in the cycle after its byte is accepted.
// s_tready drops only while both buffer entries wait on m_tready.
// aresetn clears the framing state, the mode register and the buffer.
`default_nettype none

module chunked_body_decoder_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input bytes
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [7:0] body_byte
    input  wire logic                              s_tlast,  // stream_end
    // Results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] data_byte, [LENGTH_BITS+7:8] decoded_length, rest zero
    output logic [cbd_pkg::M_TDATA_BITS-1:0]       m_tdata,
    output logic [1:0]                             m_tuser,  // [0] has_data, [1] malformed
    output logic                                   m_tlast,  // body_done
    // Mode register write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data  // chunked_mode
);
    import cbd_pkg::*;

    logic                   mode_reg;
    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next;
    logic [DCNT_BITS-1:0]   dcnt_reg, dcnt_next;
    logic [SIZE_BITS-1:0]   left_reg, left_next;
    logic [1:0]             skip_reg, skip_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic                   err_reg, err_next;

    logic                   accept;
    logic                   emit, has, done, was_done, count;
    logic [4:0]             hv;
    logic [SIZE_BITS-1:0]   left_dec;
    result_t                res;
    result_t                out_res;
    logic                   buf_full;

    assign cfg_ready = 1'b1;
    assign s_tready  = !buf_full;
    assign accept    = s_tvalid && s_tready;
    assign hv        = hex_digit(s_tdata);
    assign left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    // Decode one byte against the framing state
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        left_next  = left_reg;
        skip_next  = skip_reg;
        total_next = total_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        has        = 1'b0;
        done       = 1'b0;
        was_done   = 1'b0;
        count      = 1'b0;

        if (!mode_reg) begin
            has   = 1'b1;
            emit  = 1'b1;
            count = 1'b1;
        end else begin
            case (phase_reg)
                PH_LF: begin
                    if (s_tdata == CH_LF) begin
                        if (dcnt_reg == '0) begin
                            err_next   = 1'b1;
                            phase_next = PH_SIZE;
                        end else if (acc_reg == '0) begin
                            done       = 1'b1;
                            emit       = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            left_next  = acc_reg;
                            phase_next = PH_DATA;
                        end
                        acc_next  = '0;
                        dcnt_next = '0;
                    end else begin
                        err_next   = 1'b1;
                        phase_next = PH_BAD;
                    end
                end
                PH_BAD: begin
                    if (s_tdata == CH_LF) begin
                        acc_next   = '0;
                        dcnt_next  = '0;
                        phase_next = PH_SIZE;
                    end
                end
                PH_DATA: begin
                    has       = 1'b1;
                    emit      = 1'b1;
                    count     = 1'b1;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        skip_next  = 2'd0;
                        phase_next = PH_TRAIL;
                    end
                end
                PH_TRAIL: begin
                    skip_next = skip_reg + 2'd1;
                    if (skip_next >= 2'd2) begin
                        skip_next  = 2'd0;
                        phase_next = PH_SIZE;
                    end
                end
                PH_DONE: begin
                    was_done = 1'b1;
                end
                default: begin
                    // Size line; stray codes fall back here as well
                    phase_next = PH_SIZE;
                    if (hv[4]) begin
                        if (dcnt_reg >= DCNT_BITS'(MAX_HEX_DIGITS)) begin
                            err_next   = 1'b1;
                            phase_next = PH_BAD;
                        end else begin
                            acc_next  = {acc_reg[SIZE_BITS-5:0], hv[3:0]};
                            dcnt_next = dcnt_reg + 1'b1;
                        end
                    end else if (s_tdata == CH_CR) begin
                        phase_next = PH_LF;
                    end else if (s_tdata == CH_LF) begin
                        err_next  = 1'b1;
                        acc_next  = '0;
                        dcnt_next = '0;
                    end else begin
                        err_next   = 1'b1;
                        phase_next = PH_BAD;
                    end
                end
            endcase
        end

        // Count payload bytes, saturating
        if (count && (total_reg != '1)) begin
            total_next = total_reg + 1'b1;
        end

        if (s_tlast && !was_done) begin
            emit = 1'b1;
            done = 1'b1;
        end

        res.data_byte      = has ? s_tdata : 8'h00;
        res.has_data       = has;
        res.body_done      = done;
        res.malformed      = err_next;
        res.decoded_length = total_next;

        // Return to the start of a body after its last byte
        if (s_tlast) begin
            phase_next = PH_SIZE;
            acc_next   = '0;
            dcnt_next  = '0;
            left_next  = '0;
            skip_next  = 2'd0;
            total_next = '0;
            err_next   = 1'b0;
        end
    end

    // Hold framing state and mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            phase_reg <= PH_SIZE;
            acc_reg   <= '0;
            dcnt_reg  <= '0;
            left_reg  <= '0;
            skip_reg  <= 2'd0;
            total_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                dcnt_reg  <= dcnt_next;
                left_reg  <= left_next;
                skip_reg  <= skip_next;
                total_reg <= total_next;
                err_reg   <= err_next;
            end
        end
    end

    cbd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && emit),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result channel
    assign m_tdata = M_TDATA_BITS'({out_res.decoded_length, out_res.data_byte});
    assign m_tuser = {out_res.malformed, out_res.has_data};
    assign m_tlast = out_res.body_done;

endmodule

`default_nettype wire
